FILE: design/bitmap_frame_allocator_assert.svh
// assertion macros for the bitmap frame allocator
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/bfa_pkg.sv
// types and constants of the bitmap frame allocator
package bfa_pkg;
  localparam int NUM_FRAMES = 65536;
  localparam int RESERVED_LOW_FRAMES = 256;
  localparam int MAP_WORD_BITS = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int MAP_DEPTH = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW = $clog2(MAP_DEPTH);
  localparam int BW = $clog2(MAP_WORD_BITS);
  localparam int CW = 17;
  localparam int KFW = 16;
  localparam int ADW = 32;
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_KERNEL_FIRST = 2'd0;
  localparam logic [CFG_IW-1:0] REG_KERNEL_END = 2'd1;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_REGION = 2'd2;
  localparam logic [CW-1:0] KERNEL_RESET = 17'd256;
  localparam logic [64:0] LIMIT_BYTES = 65'(NUM_FRAMES) << PAGE_SHIFT;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_OOM = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_RANGE = 3'd3,
    ST_RESERVED = 3'd4,
    ST_DOUBLE = 3'd5,
    ST_IGNORED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_PREP, S_RD, S_CHK, S_FIN
  } state_e;
endpackage

FILE: design/bfa_ram.sv
// generic single port ram with registered read
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

FILE: design/bitmap_frame_allocator.sv
// bitmap frame allocator top level
// each map word visited takes a ram read, then a check and write back
// every word: prepare, then a read and a check per map word visited, then finish; a word rejected early skips to finish
// one word at a time; the next is taken once the result is registered
// after reset a clearing pass sets every map word to all ones; no input is taken until it ends
`include "bitmap_frame_allocator_assert.svh"
module bitmap_frame_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bfa_pkg::CFG_IW-1:0]       cfg_index_i,
  input  logic [bfa_pkg::CW-1:0]           cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [31:0]                      free_address_i,
  input  logic [63:0]                      region_base_i,
  input  logic [63:0]                      region_length_i,
  input  logic [31:0]                      region_type_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      frame_address_o,
  output logic [2:0]                       status_o,
  output logic [bfa_pkg::CW-1:0]           free_frames_o,
  output logic [bfa_pkg::CW-1:0]           total_frames_o
);
  localparam int WB = bfa_pkg::MAP_WORD_BITS;
  localparam int AW = bfa_pkg::AW;
  localparam int BW = bfa_pkg::BW;
  localparam int CW = bfa_pkg::CW;

  bfa_pkg::state_e state_q, state_d;
  logic [AW-1:0] w_q, w_d, wlast_q, wlast_d, clr_q, clr_d;
  logic [1:0] cmd_q;
  logic [31:0] addr_q, type_q;
  logic [63:0] base_q, len_q;
  logic [CW-1:0] sf_q, sf_d, ef_q, ef_d;
  logic [CW-1:0] free_count_q, free_count_d, limit_q, limit_d;
  logic [CW-1:0] kf_q, ke_q;
  logic [WB-1:0] pc_q, pc_d;
  bfa_pkg::status_e st_q, st_d;
  logic [31:0] fa_q, fa_d;
  logic out_valid_q;
  logic [31:0] out_fa_q;
  bfa_pkg::status_e out_st_q;
  logic [CW-1:0] out_free_q, out_total_q;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [WB-1:0] ram_wdata, ram_rdata;

  logic in_acc, fin_go, inc, dec;
  logic [64:0] sum, rend;
  logic [CW-1:0] ef_c, sf_c, next_start;
  logic [19:0] ffr;
  logic [WB-1:0] avail, lsb, rmask;
  logic [BW-1:0] bidx;

  function automatic logic [WB-1:0] ge_mask(logic [CW-1:0] bound, logic [AW-1:0] w);
    logic [CW-1:0] ws, diff;
    ws = CW'(w) << BW;
    diff = bound - ws;
    if (bound <= ws) ge_mask = '1;
    else if (diff >= CW'(WB)) ge_mask = '0;
    else ge_mask = {WB{1'b1}} << diff[BW-1:0];
  endfunction

  bfa_ram #(.WIDTH(WB), .DEPTH(bfa_pkg::MAP_DEPTH)) u_map (
    .clk_i(clk_i), .we_i(ram_we), .re_i(ram_re), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != bfa_pkg::S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign fin_go = (state_q == bfa_pkg::S_FIN) && !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    w_d = w_q;
    wlast_d = wlast_q;
    clr_d = clr_q;
    sf_d = sf_q;
    ef_d = ef_q;
    limit_d = limit_q;
    st_d = st_q;
    fa_d = fa_q;
    pc_d = '0;
    inc = 1'b0;
    dec = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_addr = w_q;
    ram_wdata = ram_rdata;
    sum = {1'b0, base_q} + {1'b0, len_q};
    rend = sum[64] ? {1'b0, {64{1'b1}}} : sum;
    if (rend > bfa_pkg::LIMIT_BYTES) rend = bfa_pkg::LIMIT_BYTES;
    ef_c = rend[bfa_pkg::PAGE_SHIFT +: CW];
    sf_c = CW'(base_q[bfa_pkg::PAGE_SHIFT +: bfa_pkg::KFW]);
    ffr = addr_q[31:bfa_pkg::PAGE_SHIFT];
    next_start = CW'((AW + 1)'(w_q) + 1'b1) << BW;
    avail = ~ram_rdata & ge_mask(CW'(bfa_pkg::RESERVED_LOW_FRAMES), w_q)
            & ~ge_mask(limit_q, w_q);
    lsb = avail & (~avail + 1'b1);
    bidx = '0;
    for (int i = 0; i < WB; i++) begin
      if (lsb[i]) bidx = bidx | BW'(i);
    end
    rmask = ram_rdata & ge_mask(sf_q, w_q) & ~ge_mask(ef_q, w_q)
            & ge_mask(CW'(bfa_pkg::RESERVED_LOW_FRAMES), w_q)
            & ~(ge_mask(kf_q, w_q) & ~ge_mask(ke_q, w_q));
    unique case (state_q)
      bfa_pkg::S_CLR: begin
        ram_we = 1'b1;
        ram_addr = clr_q;
        ram_wdata = '1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(bfa_pkg::MAP_DEPTH - 1)) state_d = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_IDLE: begin
        if (in_acc) state_d = bfa_pkg::S_PREP;
      end
      bfa_pkg::S_PREP: begin
        fa_d = '0;
        st_d = bfa_pkg::ST_OK;
        state_d = bfa_pkg::S_RD;
        priority case (cmd_q)
          bfa_pkg::CMD_ALLOC: begin
            w_d = AW'(bfa_pkg::RESERVED_LOW_FRAMES / WB);
            if (CW'(bfa_pkg::RESERVED_LOW_FRAMES) >= limit_q) begin
              st_d = bfa_pkg::ST_OOM;
              state_d = bfa_pkg::S_FIN;
            end
          end
          bfa_pkg::CMD_FREE: begin
            w_d = ffr[BW +: AW];
            priority if (addr_q[bfa_pkg::PAGE_SHIFT-1:0] != '0) begin
              st_d = bfa_pkg::ST_UNALIGNED;
              state_d = bfa_pkg::S_FIN;
            end else if (ffr >= 20'(limit_q)) begin
              st_d = bfa_pkg::ST_RANGE;
              state_d = bfa_pkg::S_FIN;
            end else if (ffr < 20'(bfa_pkg::RESERVED_LOW_FRAMES)) begin
              st_d = bfa_pkg::ST_RESERVED;
              state_d = bfa_pkg::S_FIN;
            end
          end
          bfa_pkg::CMD_REGION: begin
            if (type_q != 32'd1 || {1'b0, base_q} >= bfa_pkg::LIMIT_BYTES) begin
              st_d = bfa_pkg::ST_IGNORED;
              state_d = bfa_pkg::S_FIN;
            end else begin
              if (ef_c > limit_q) limit_d = ef_c;
              sf_d = sf_c;
              ef_d = ef_c;
              w_d = sf_c[BW +: AW];
              wlast_d = AW'((ef_c - 1'b1) >> BW);
              if (ef_c <= sf_c) state_d = bfa_pkg::S_FIN;
            end
          end
          default: begin
            st_d = bfa_pkg::ST_IGNORED;
            state_d = bfa_pkg::S_FIN;
          end
        endcase
      end
      bfa_pkg::S_RD: begin
        ram_re = 1'b1;
        state_d = bfa_pkg::S_CHK;
      end
      bfa_pkg::S_CHK: begin
        priority case (cmd_q)
          bfa_pkg::CMD_ALLOC: begin
            if (avail != '0) begin
              ram_we = 1'b1;
              ram_wdata = ram_rdata | lsb;
              dec = 1'b1;
              fa_d = 32'({w_q, bidx}) << bfa_pkg::PAGE_SHIFT;
              state_d = bfa_pkg::S_FIN;
            end else if (next_start >= limit_q ||
                         w_q == AW'(bfa_pkg::MAP_DEPTH - 1)) begin
              st_d = bfa_pkg::ST_OOM;
              state_d = bfa_pkg::S_FIN;
            end else begin
              w_d = w_q + 1'b1;
              state_d = bfa_pkg::S_RD;
            end
          end
          bfa_pkg::CMD_FREE: begin
            state_d = bfa_pkg::S_FIN;
            if (!ram_rdata[ffr[BW-1:0]]) begin
              st_d = bfa_pkg::ST_DOUBLE;
            end else begin
              ram_we = 1'b1;
              ram_wdata = ram_rdata & ~(WB'(1) << ffr[BW-1:0]);
              inc = 1'b1;
            end
          end
          default: begin
            ram_we = 1'b1;
            ram_wdata = ram_rdata & ~rmask;
            pc_d = rmask;
            if (w_q == wlast_q) begin
              state_d = bfa_pkg::S_FIN;
            end else begin
              w_d = w_q + 1'b1;
              state_d = bfa_pkg::S_RD;
            end
          end
        endcase
      end
      bfa_pkg::S_FIN: begin
        if (fin_go) state_d = bfa_pkg::S_IDLE;
      end
      default: state_d = bfa_pkg::S_IDLE;
    endcase
    free_count_d = free_count_q + CW'($countones(pc_q)) + CW'(inc) - CW'(dec);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::S_CLR;
      clr_q <= '0;
      free_count_q <= '0;
      limit_q <= '0;
      pc_q <= '0;
      kf_q <= bfa_pkg::KERNEL_RESET;
      ke_q <= bfa_pkg::KERNEL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      free_count_q <= free_count_d;
      limit_q <= limit_d;
      pc_q <= pc_d;
      if (cfg_we_i && cfg_index_i == bfa_pkg::REG_KERNEL_FIRST) begin
        kf_q <= CW'(cfg_data_i[bfa_pkg::KFW-1:0]);
      end
      if (cfg_we_i && cfg_index_i == bfa_pkg::REG_KERNEL_END) begin
        ke_q <= cfg_data_i;
      end
      if (fin_go) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    wlast_q <= wlast_d;
    sf_q <= sf_d;
    ef_q <= ef_d;
    st_q <= st_d;
    fa_q <= fa_d;
    if (in_acc) begin
      cmd_q <= command_i;
      addr_q <= free_address_i;
      base_q <= region_base_i;
      len_q <= region_length_i;
      type_q <= region_type_i;
    end
    if (fin_go) begin
      out_fa_q <= fa_q;
      out_st_q <= st_q;
      out_free_q <= free_count_d;
      out_total_q <= limit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_address_o = out_fa_q;
  assign status_o = out_st_q;
  assign free_frames_o = out_free_q;
  assign total_frames_o = out_total_q;

  `BFA_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == bfa_pkg::S_FIN), "result word without finish")
  `BFA_ASSERT(a_free_le_limit, free_count_q <= limit_q, "free count above frame limit")
  `BFA_ASSERT(a_accept_prep, in_acc |=> state_q == bfa_pkg::S_PREP, "accepted word not started")
  `BFA_ASSERT_ALWAYS(a_ram_excl, !(ram_we && ram_re), "map read and write together")
endmodule
